// File: src/utf8_decode_classify_top_defines.svh
// ----------------------------------------------------------------------------
// utf8_decode_classify_top_defines
// Assertion macros used by the UTF-8 decoder RTL (utf8dc_decode).
// ----------------------------------------------------------------------------
`ifndef UTF8_DECODE_CLASSIFY_TOP_DEFINES_SVH
`define UTF8_DECODE_CLASSIFY_TOP_DEFINES_SVH

// plain property, checked while out of reset
`define UDC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("utf8 decoder check failed");

// antecedent in this cycle, consequent in the next
`define UDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8 decoder sequence check failed");

`endif

// File: src/utf8dc_pkg.sv
// ----------------------------------------------------------------------------
// utf8dc_pkg
// Widths, class codes and shared types of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8dc_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 31;
  localparam int CLS_W  = 4;
  localparam int BC_W   = 3;

  localparam logic [CLS_W-1:0] CLS_LATIN    = 4'd0;
  localparam logic [CLS_W-1:0] CLS_GREEK    = 4'd1;
  localparam logic [CLS_W-1:0] CLS_CYRILLIC = 4'd2;
  localparam logic [CLS_W-1:0] CLS_ARMENIAN = 4'd3;
  localparam logic [CLS_W-1:0] CLS_HEBREW   = 4'd4;
  localparam logic [CLS_W-1:0] CLS_ARABIC   = 4'd5;
  localparam logic [CLS_W-1:0] CLS_CJK      = 4'd6;
  localparam logic [CLS_W-1:0] CLS_PUNCT    = 4'd7;
  localparam logic [CLS_W-1:0] CLS_DIGIT    = 4'd8;
  localparam logic [CLS_W-1:0] CLS_EMOJI    = 4'd9;
  localparam logic [CLS_W-1:0] CLS_UNKNOWN  = 4'd10;

  // decoder to top: a finished character, if any
  typedef struct packed {
    logic              emit;
    logic [CP_W-1:0]   code;
    logic [BC_W-1:0]   count;
  } dec_res_t;

endpackage

// File: src/utf8_decode_classify_top.sv
// ----------------------------------------------------------------------------
// utf8_decode_classify_top
// Streaming UTF-8 decoder with script class and display width per character.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data_byte) takes one raw byte a
// cycle while in_ready is high. Output channel (out_valid/out_ready and
// out_ payload) gives one result per completed sequence: code point,
// script class, double-width flag and the number of bytes the sequence
// used. Bytes that only continue a sequence produce no result.
// A byte is held in the input register, then decoded and classified on
// the way into the result register, from which the result of the final
// byte of a sequence is shown.
// Throughput: one byte every cycle while the receiver takes results, set
// by the single input register and the single result register; the result
// register is refilled in the same cycle it is taken.
// Reset (rst_n low at a clock edge) empties both registers and drops any
// partly assembled sequence.
// A stalled receiver holds the result; a byte that would complete a
// sequence then waits in the input register, and in_ready falls once that
// register is also full. Bytes that complete nothing keep flowing.
// ----------------------------------------------------------------------------
module utf8_decode_classify_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [utf8dc_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [utf8dc_pkg::CP_W-1:0]    out_code_point,
  output logic [utf8dc_pkg::CLS_W-1:0]   out_script_class,
  output logic                           out_full_width,
  output logic [utf8dc_pkg::BC_W-1:0]    out_byte_count
);
  import utf8dc_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_valid_r, out_valid_nxt;
  logic [CP_W-1:0]   code_r;
  logic [CLS_W-1:0]  class_r;
  logic              wide_r;
  logic [BC_W-1:0]   count_r;

  dec_res_t          dec_res;
  logic [CLS_W-1:0]  cls;
  logic              wide;
  logic              out_space;
  logic              s1_fire;
  logic              load_out;

  utf8dc_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_i    (s1_byte_r),
    .advance_i (s1_fire),
    .res_o     (dec_res)
  );

  utf8dc_classify u_classify (
    .code_i  (dec_res.code),
    .class_o (cls),
    .wide_o  (wide)
  );

  assign out_space     = !out_valid_r || out_ready;
  assign s1_fire       = s1_valid_r && (!dec_res.emit || out_space);
  assign load_out      = s1_fire && dec_res.emit;
  assign in_ready      = !s1_valid_r || s1_fire;
  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = load_out || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
    end
    if (load_out) begin
      code_r  <= dec_res.code;
      class_r <= cls;
      wide_r  <= wide;
      count_r <= dec_res.count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_point   = code_r;
  assign out_script_class = class_r;
  assign out_full_width   = wide_r;
  assign out_byte_count   = count_r;

endmodule

// File: src/utf8dc_decode.sv
// ----------------------------------------------------------------------------
// utf8dc_decode
// Sequence tracker: lead byte decoding and continuation byte assembly.
// ----------------------------------------------------------------------------
`include "utf8_decode_classify_top_defines.svh"

module utf8dc_decode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [utf8dc_pkg::BYTE_W-1:0] byte_i,
  input  logic                          advance_i,
  output utf8dc_pkg::dec_res_t          res_o
);
  import utf8dc_pkg::*;

  logic [BC_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [BC_W-1:0] seq_len_r, seq_len_nxt;
  logic [CP_W-1:0] partial_r, partial_nxt;
  logic [CP_W-1:0] shifted;

  assign shifted = {partial_r[CP_W-7:0], byte_i[5:0]};

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    seq_len_nxt    = seq_len_r;
    partial_nxt    = partial_r;
    res_o.emit     = 1'b0;
    res_o.code     = shifted;
    res_o.count    = seq_len_r;
    if (bytes_left_r != '0) begin
      // pending sequence: every byte counts as a continuation
      if (bytes_left_r == BC_W'(1)) begin
        res_o.emit     = 1'b1;
        bytes_left_nxt = '0;
        seq_len_nxt    = '0;
        partial_nxt    = '0;
      end else begin
        bytes_left_nxt = bytes_left_r - BC_W'(1);
        partial_nxt    = shifted;
      end
    end else begin
      priority if (byte_i[7:6] != 2'b11) begin
        res_o.emit  = 1'b1;
        res_o.code  = CP_W'(byte_i);
        res_o.count = BC_W'(1);
      end else if (byte_i[5] == 1'b0) begin
        seq_len_nxt = BC_W'(2);
        partial_nxt = CP_W'(byte_i[4:0]);
      end else if (byte_i[4] == 1'b0) begin
        seq_len_nxt = BC_W'(3);
        partial_nxt = CP_W'(byte_i[3:0]);
      end else if (byte_i[3] == 1'b0) begin
        seq_len_nxt = BC_W'(4);
        partial_nxt = CP_W'(byte_i[2:0]);
      end else if (byte_i[2] == 1'b0) begin
        seq_len_nxt = BC_W'(5);
        partial_nxt = CP_W'(byte_i[1:0]);
      end else begin
        // 0xfc to 0xff, six-byte lead
        seq_len_nxt = BC_W'(6);
        partial_nxt = CP_W'(byte_i[0]);
      end
      if (byte_i[7:6] == 2'b11) begin
        bytes_left_nxt = seq_len_nxt - BC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      seq_len_r    <= '0;
      partial_r    <= '0;
    end else if (advance_i) begin
      bytes_left_r <= bytes_left_nxt;
      seq_len_r    <= seq_len_nxt;
      partial_r    <= partial_nxt;
    end
  end

  `UDC_ASSERT(a_left_below_len, clk, rst_n,
    (bytes_left_r == '0) || ((seq_len_r >= BC_W'(2)) && (bytes_left_r < seq_len_r)))
  `UDC_ASSERT_NEXT(a_emit_clears, clk, rst_n, advance_i && res_o.emit,
    (bytes_left_r == '0) && (partial_r == '0))
  `UDC_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, !advance_i,
    $stable(bytes_left_r) && $stable(seq_len_r) && $stable(partial_r))

endmodule

// File: src/utf8dc_classify.sv
// ----------------------------------------------------------------------------
// utf8dc_classify
// Script class by ordered range tests and the double-width display flag.
// ----------------------------------------------------------------------------
module utf8dc_classify (
  input  logic [utf8dc_pkg::CP_W-1:0]  code_i,
  output logic [utf8dc_pkg::CLS_W-1:0] class_o,
  output logic                         wide_o
);
  import utf8dc_pkg::*;

  function automatic logic in_rng(input logic [CP_W-1:0] v,
                                  input logic [CP_W-1:0] lo,
                                  input logic [CP_W-1:0] hi);
    in_rng = (v >= lo) && (v <= hi);
  endfunction

  logic cjk, emoji, latin, punct;

  always_comb begin
    cjk = in_rng(code_i, 31'h1100, 31'h115F) || in_rng(code_i, 31'h2E80, 31'h303E) ||
          in_rng(code_i, 31'h3041, 31'h33FF) || in_rng(code_i, 31'h3400, 31'h4DBF) ||
          in_rng(code_i, 31'h4E00, 31'h9FFF) || in_rng(code_i, 31'hF900, 31'hFAFF) ||
          in_rng(code_i, 31'hFE30, 31'hFE6F) || in_rng(code_i, 31'h20000, 31'h3FFFD);
    emoji = in_rng(code_i, 31'h1F300, 31'h1F64F) || in_rng(code_i, 31'h1F900, 31'h1F9FF);
    latin = in_rng(code_i, 31'h41, 31'h5A) || in_rng(code_i, 31'h61, 31'h7A) ||
            in_rng(code_i, 31'h80, 31'h24F);
    punct = in_rng(code_i, 31'h20, 31'h2F) || in_rng(code_i, 31'h3A, 31'h40) ||
            in_rng(code_i, 31'h5B, 31'h60) || in_rng(code_i, 31'h7B, 31'h7E) ||
            in_rng(code_i, 31'h2000, 31'h206F) || in_rng(code_i, 31'h3000, 31'h303F);

    wide_o = cjk || emoji || in_rng(code_i, 31'hA000, 31'hA4CF) ||
             in_rng(code_i, 31'hAC00, 31'hD7A3) || in_rng(code_i, 31'hFF00, 31'hFF60) ||
             in_rng(code_i, 31'hFFE0, 31'hFFE6);

    // first matching range wins
    priority if (latin)                                  class_o = CLS_LATIN;
    else if (in_rng(code_i, 31'h370, 31'h3FF))           class_o = CLS_GREEK;
    else if (in_rng(code_i, 31'h400, 31'h52F))           class_o = CLS_CYRILLIC;
    else if (in_rng(code_i, 31'h530, 31'h58F))           class_o = CLS_ARMENIAN;
    else if (in_rng(code_i, 31'h590, 31'h5FF))           class_o = CLS_HEBREW;
    else if (in_rng(code_i, 31'h600, 31'h6FF))           class_o = CLS_ARABIC;
    else if (cjk)                                        class_o = CLS_CJK;
    else if (punct)                                      class_o = CLS_PUNCT;
    else if (in_rng(code_i, 31'h30, 31'h39))             class_o = CLS_DIGIT;
    else if (emoji)                                      class_o = CLS_EMOJI;
    else                                                 class_o = CLS_UNKNOWN;
  end

endmodule
